@@ src/ccint_pkg.sv @@
// ----------------------------------------------------------------------------
// ccint_pkg
// Shared types and constants for the circle-circle intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccint_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned RadWidth   = 2 * CoordWidth - 2;
  localparam int unsigned MulDigit   = 16;

  typedef struct packed {
    logic                         side;
    logic signed [CoordWidth-1:0] cx0;
    logic signed [CoordWidth-1:0] cy0;
    logic        [RadWidth-1:0]   rad0_sq;
    logic signed [CoordWidth-1:0] cx1;
    logic signed [CoordWidth-1:0] cy1;
    logic        [RadWidth-1:0]   rad1_sq;
  } ccint_in_t;

  typedef struct packed {
    logic                         found;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
  } ccint_out_t;

endpackage

`default_nettype wire

@@ src/ccint_mul.sv @@
// ----------------------------------------------------------------------------
// ccint_mul
// Unsigned multiplier built as a chain of digit cells; each cell adds one
// digit row of the product and passes operands and tag to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ccint_mul #(
  parameter int unsigned AW  = 32,
  parameter int unsigned BW  = 32,
  parameter int unsigned TW  = 1,
  parameter int unsigned DIG = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  input  wire logic [TW-1:0]    tag_i,
  output logic                  valid_o,
  output logic [AW+BW-1:0]      prod_o,
  output logic [TW-1:0]         tag_o
);

  localparam int unsigned NS  = (BW + DIG - 1) / DIG;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned BPW = NS * DIG;

  logic          v_q   [NS];
  logic [PW-1:0] a_q   [NS];
  logic [PW-1:0] acc_q [NS];
  logic [BPW-1:0] b_q  [NS];
  logic [TW-1:0] tag_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_cell
    logic           v_in;
    logic [PW-1:0]  a_in;
    logic [PW-1:0]  acc_in;
    logic [BPW-1:0] b_in;
    logic [TW-1:0]  t_in;

    if (i == 0) begin : g_head
      assign v_in   = valid_i;
      assign a_in   = PW'(a_i);
      assign acc_in = '0;
      assign b_in   = BPW'(b_i);
      assign t_in   = tag_i;
    end else begin : g_link
      assign v_in   = v_q[i-1];
      assign a_in   = a_q[i-1];
      assign acc_in = acc_q[i-1];
      assign b_in   = b_q[i-1];
      assign t_in   = tag_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    // add this digit row, then advance to the next digit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i] <= acc_in + a_in * PW'(b_in[DIG-1:0]);
        a_q[i]   <= a_in << DIG;
        b_q[i]   <= b_in >> DIG;
        tag_q[i] <= t_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign prod_o  = acc_q[NS-1];
  assign tag_o   = tag_q[NS-1];

endmodule

`default_nettype wire

@@ src/ccint_sqrt.sv @@
// ----------------------------------------------------------------------------
// ccint_sqrt
// Floor square root as a chain of cells, one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ccint_sqrt #(
  parameter int unsigned IW = 130,
  parameter int unsigned TW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [IW-1:0]    n_i,
  input  wire logic [TW-1:0]    tag_i,
  output logic                  valid_o,
  output logic [IW/2-1:0]       root_o,
  output logic [TW-1:0]         tag_o
);

  localparam int unsigned RTW  = IW / 2;
  localparam int unsigned REMW = RTW + 2;

  logic            v_q    [RTW];
  logic [IW-1:0]   n_q    [RTW];
  logic [REMW-1:0] rem_q  [RTW];
  logic [RTW-1:0]  root_q [RTW];
  logic [TW-1:0]   tag_q  [RTW];

  for (genvar i = 0; i < RTW; i++) begin : g_cell
    logic            v_in;
    logic [IW-1:0]   n_in;
    logic [REMW-1:0] rem_in;
    logic [RTW-1:0]  root_in;
    logic [TW-1:0]   t_in;
    logic [REMW+1:0] cand;
    logic [REMW+1:0] trial;
    logic            ge;

    if (i == 0) begin : g_head
      assign v_in    = valid_i;
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign t_in    = tag_i;
    end else begin : g_link
      assign v_in    = v_q[i-1];
      assign n_in    = n_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign t_in    = tag_q[i-1];
    end

    // bring down two bits, try (root << 2) | 1
    assign cand  = {rem_in, n_in[IW-1 -: 2]};
    assign trial = (REMW+2)'({root_in, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? REMW'(cand - trial) : REMW'(cand);
        root_q[i] <= {root_in[RTW-2:0], ge};
        n_q[i]    <= n_in << 2;
        tag_q[i]  <= t_in;
      end
    end
  end

  assign valid_o = v_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign tag_o   = tag_q[RTW-1];

endmodule

`default_nettype wire

@@ src/ccint_div.sv @@
// ----------------------------------------------------------------------------
// ccint_div
// Restoring divider as a chain of cells, one quotient bit per cell. The
// caller hands in a partial remainder already below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ccint_div #(
  parameter int unsigned DW = 66,
  parameter int unsigned QW = 34,
  parameter int unsigned TW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [DW-1:0]    rem_i,
  input  wire logic [QW-1:0]    bits_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [TW-1:0]    tag_i,
  output logic                  valid_o,
  output logic [QW-1:0]         quot_o,
  output logic [TW-1:0]         tag_o
);

  logic          v_q    [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] bits_q [QW];
  logic [QW-1:0] quot_q [QW];
  logic [DW-1:0] den_q  [QW];
  logic [TW-1:0] tag_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_cell
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quot_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] t_in;
    logic [DW:0]   cand;
    logic          ge;

    if (i == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign bits_in = bits_i;
      assign quot_in = '0;
      assign den_in  = den_i;
      assign t_in    = tag_i;
    end else begin : g_link
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign bits_in = bits_q[i-1];
      assign quot_in = quot_q[i-1];
      assign den_in  = den_q[i-1];
      assign t_in    = tag_q[i-1];
    end

    assign cand = {rem_in, bits_in[QW-1]};
    assign ge   = cand >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? DW'(cand - {1'b0, den_in}) : DW'(cand);
        bits_q[i] <= bits_in << 1;
        quot_q[i] <= {quot_in[QW-2:0], ge};
        den_q[i]  <= den_in;
        tag_q[i]  <= t_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

`default_nettype wire

@@ src/circle_circle_intersection_unit.sv @@
// ----------------------------------------------------------------------------
// circle_circle_intersection_unit
// Pipelined circle-circle intersection point in exact fixed point.
// ----------------------------------------------------------------------------
// Takes one query per clock while the output is not held and returns one
// result per query, in order. At the default 32-bit coordinates the path
// runs: input register, squaring (2 digit cells), sum stage, radius and k
// products (5 digit cells), discriminant stage, the 65-cell square-root
// chain, the cross products (2 digit cells), two numerator stages, the
// 34-cell divider chain and the output register. The square-root chain is
// the longest of these. When the output is held the whole pipeline holds.
`default_nettype none

module circle_circle_intersection_unit #(
  parameter int unsigned DigitWidth = ccint_pkg::MulDigit
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ccint_pkg::ccint_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ccint_pkg::ccint_out_t      out_data_o
);

  import ccint_pkg::*;

  localparam int unsigned W    = CoordWidth;
  localparam int unsigned RW   = RadWidth;
  localparam int unsigned D2W  = 2 * W + 1;
  localparam int unsigned KW   = 2 * W + 3;
  localparam int unsigned KMW  = 2 * W + 2;
  localparam int unsigned SQW  = 4 * W + 2;
  localparam int unsigned RTW  = SQW / 2;
  localparam int unsigned DSW  = 4 * W + 5;
  localparam int unsigned PW1  = 2 * W;
  localparam int unsigned PW2A = RW + KMW;
  localparam int unsigned PW2B = 2 * KMW;
  localparam int unsigned PW3  = KMW + W;
  localparam int unsigned NW   = 3 * W + 5;
  localparam int unsigned MAGW = 3 * W + 5;
  localparam int unsigned DENW = 2 * W + 2;
  localparam int unsigned QW   = W + 2;
  localparam int unsigned SUMW = W + 4;

  typedef struct packed {
    logic         side;
    logic [W-1:0] x0;
    logic [W-1:0] y0;
    logic         sdx;
    logic [W-1:0] magdx;
  } t1a_t;

  typedef struct packed {
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic          sdy;
    logic [W-1:0]  magdy;
  } t1b_t;

  typedef struct packed {
    logic           side;
    logic [W-1:0]   x0;
    logic [W-1:0]   y0;
    logic           sdx;
    logic [W-1:0]   magdx;
    logic           sdy;
    logic [W-1:0]   magdy;
    logic [RW-1:0]  r0;
    logic [D2W-1:0] d2;
    logic [KW-1:0]  k;
  } s1_t;

  typedef struct packed {
    logic           side;
    logic [W-1:0]   x0;
    logic [W-1:0]   y0;
    logic           sdx;
    logic [W-1:0]   magdx;
    logic [D2W-1:0] d2;
  } t2a_t;

  typedef struct packed {
    logic           sdy;
    logic [W-1:0]   magdy;
    logic [KMW-1:0] magk;
    logic           ksign;
  } t2b_t;

  typedef struct packed {
    logic           side;
    logic [W-1:0]   x0;
    logic [W-1:0]   y0;
    logic           sdx;
    logic [W-1:0]   magdx;
    logic           sdy;
    logic [W-1:0]   magdy;
    logic [KMW-1:0] magk;
    logic           ksign;
    logic [D2W-1:0] d2;
    logic           found;
  } t3_t;

  typedef struct packed {
    logic [W-1:0]   x0;
    logic [W-1:0]   y0;
    logic [D2W-1:0] d2;
    logic           found;
    logic           sign_a;
  } t4a_t;

  typedef struct packed {
    logic [NW-1:0]  numx;
    logic [NW-1:0]  numy;
    logic [D2W-1:0] d2;
    logic [W-1:0]   x0;
    logic [W-1:0]   y0;
    logic           found;
  } s4_t;

  typedef struct packed {
    logic [MAGW-1:0] mx;
    logic [MAGW-1:0] my;
    logic            negx;
    logic            negy;
    logic [DENW-1:0] den;
    logic [W-1:0]    x0;
    logic [W-1:0]    y0;
    logic            found;
  } s5_t;

  typedef struct packed {
    logic [W-1:0] x0;
    logic         neg;
    logic         ovf;
    logic         found;
  } tdx_t;

  typedef struct packed {
    logic [W-1:0] y0;
    logic         neg;
    logic         ovf;
  } tdy_t;

  // Offset the center by the signed quotient and saturate to the coordinate range.
  function automatic logic [W-1:0] place(input logic [W-1:0] base, input logic neg,
                                         input logic ovf, input logic [QW-1:0] qm);
    logic signed [QW:0]     qs;
    logic signed [SUMW-1:0] sum;
    logic        [W-1:0]    hi;
    logic        [W-1:0]    lo;
    logic        [W-1:0]    res;
    hi  = {1'b0, {(W-1){1'b1}}};
    lo  = ~hi;
    qs  = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    sum = SUMW'($signed(base)) + SUMW'(qs);
    if (ovf) begin
      res = neg ? lo : hi;
    end else if (sum > $signed({{(SUMW-W){1'b0}}, hi})) begin
      res = hi;
    end else if (sum < $signed({{(SUMW-W){1'b1}}, lo})) begin
      res = lo;
    end else begin
      res = sum[W-1:0];
    end
    return res;
  endfunction

  logic en;
  logic out_valid_q;
  ccint_out_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---- input register
  logic      v0_q;
  ccint_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  logic [W:0] dx;
  logic [W:0] dy;
  logic [W:0] ndx;
  logic [W:0] ndy;
  t1a_t       t1a_in;
  t1b_t       t1b_in;

  assign dx  = {in_q.cx1[W-1], in_q.cx1} - {in_q.cx0[W-1], in_q.cx0};
  assign dy  = {in_q.cy1[W-1], in_q.cy1} - {in_q.cy0[W-1], in_q.cy0};
  assign ndx = -dx;
  assign ndy = -dy;

  assign t1a_in.side  = in_q.side;
  assign t1a_in.x0    = in_q.cx0;
  assign t1a_in.y0    = in_q.cy0;
  assign t1a_in.sdx   = dx[W];
  assign t1a_in.magdx = dx[W] ? ndx[W-1:0] : dx[W-1:0];
  assign t1b_in.r0    = in_q.rad0_sq;
  assign t1b_in.r1    = in_q.rad1_sq;
  assign t1b_in.sdy   = dy[W];
  assign t1b_in.magdy = dy[W] ? ndy[W-1:0] : dy[W-1:0];

  // ---- squares of the center offsets
  logic           v1a, v1b;
  logic [PW1-1:0] p1a, p1b;
  t1a_t           t1a_out;
  t1b_t           t1b_out;

  ccint_mul #(.AW(W), .BW(W), .TW($bits(t1a_t)), .DIG(DigitWidth)) u_mul_dx2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q),
    .a_i(t1a_in.magdx), .b_i(t1a_in.magdx), .tag_i(t1a_in),
    .valid_o(v1a), .prod_o(p1a), .tag_o(t1a_out)
  );

  ccint_mul #(.AW(W), .BW(W), .TW($bits(t1b_t)), .DIG(DigitWidth)) u_mul_dy2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q),
    .a_i(t1b_in.magdy), .b_i(t1b_in.magdy), .tag_i(t1b_in),
    .valid_o(v1b), .prod_o(p1b), .tag_o(t1b_out)
  );

  logic [D2W-1:0] d2_c;
  logic           v1_q;
  s1_t            s1_q;

  assign d2_c = D2W'(p1a) + D2W'(p1b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v1a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.side  <= t1a_out.side;
      s1_q.x0    <= t1a_out.x0;
      s1_q.y0    <= t1a_out.y0;
      s1_q.sdx   <= t1a_out.sdx;
      s1_q.magdx <= t1a_out.magdx;
      s1_q.sdy   <= t1b_out.sdy;
      s1_q.magdy <= t1b_out.magdy;
      s1_q.r0    <= t1b_out.r0;
      s1_q.d2    <= d2_c;
      s1_q.k     <= KW'(t1b_out.r0) - KW'(t1b_out.r1) + KW'(d2_c);
    end
  end

  // ---- r0*d2 and k*k
  logic [KW-1:0] nk;
  t2a_t          t2a_in;
  t2b_t          t2b_in;

  assign nk            = -s1_q.k;
  assign t2a_in.side   = s1_q.side;
  assign t2a_in.x0     = s1_q.x0;
  assign t2a_in.y0     = s1_q.y0;
  assign t2a_in.sdx    = s1_q.sdx;
  assign t2a_in.magdx  = s1_q.magdx;
  assign t2a_in.d2     = s1_q.d2;
  assign t2b_in.sdy    = s1_q.sdy;
  assign t2b_in.magdy  = s1_q.magdy;
  assign t2b_in.ksign  = s1_q.k[KW-1];
  assign t2b_in.magk   = s1_q.k[KW-1] ? nk[KMW-1:0] : s1_q.k[KMW-1:0];

  logic            v2a, v2b;
  logic [PW2A-1:0] p2a;
  logic [PW2B-1:0] p2b;
  t2a_t            t2a_out;
  t2b_t            t2b_out;

  ccint_mul #(.AW(RW), .BW(KMW), .TW($bits(t2a_t)), .DIG(DigitWidth)) u_mul_rd (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q),
    .a_i(s1_q.r0), .b_i(KMW'(s1_q.d2)), .tag_i(t2a_in),
    .valid_o(v2a), .prod_o(p2a), .tag_o(t2a_out)
  );

  ccint_mul #(.AW(KMW), .BW(KMW), .TW($bits(t2b_t)), .DIG(DigitWidth)) u_mul_kk (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q),
    .a_i(t2b_in.magk), .b_i(t2b_in.magk), .tag_i(t2b_in),
    .valid_o(v2b), .prod_o(p2b), .tag_o(t2b_out)
  );

  // ---- discriminant
  logic [DSW-1:0] disc;
  logic           found_c;
  logic           v3_q;
  t3_t            t3_q;
  logic [SQW-1:0] disc_q;

  assign disc    = DSW'({p2a, 2'b00}) - DSW'(p2b);
  assign found_c = (t2a_out.d2 != '0) && !disc[DSW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q.side  <= t2a_out.side;
      t3_q.x0    <= t2a_out.x0;
      t3_q.y0    <= t2a_out.y0;
      t3_q.sdx   <= t2a_out.sdx;
      t3_q.magdx <= t2a_out.magdx;
      t3_q.sdy   <= t2b_out.sdy;
      t3_q.magdy <= t2b_out.magdy;
      t3_q.magk  <= t2b_out.magk;
      t3_q.ksign <= t2b_out.ksign;
      t3_q.d2    <= t2a_out.d2;
      t3_q.found <= found_c;
      disc_q     <= found_c ? SQW'(disc) : '0;
    end
  end

  // ---- square root of the discriminant
  logic           v4s;
  logic [RTW-1:0] root;
  t3_t            t3_out;

  ccint_sqrt #(.IW(SQW), .TW($bits(t3_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .n_i(disc_q), .tag_i(t3_q),
    .valid_o(v4s), .root_o(root), .tag_o(t3_out)
  );

  // pick the root: larger y on a horizontal baseline, else by side
  logic neg_t;

  always_comb begin
    if (t3_out.magdy == '0) begin
      neg_t = t3_out.sdx;
    end else if (!t3_out.side) begin
      neg_t = !t3_out.sdy;
    end else begin
      neg_t = t3_out.sdy;
    end
  end

  t4a_t           t4a_in;
  t4a_t           t4a_out;
  logic           sgn_b, sgn_c, sgn_d;
  logic           v5a, v5b, v5c, v5d;
  logic [PW3-1:0] pa, pb, pc, pd;

  assign t4a_in.x0     = t3_out.x0;
  assign t4a_in.y0     = t3_out.y0;
  assign t4a_in.d2     = t3_out.d2;
  assign t4a_in.found  = t3_out.found;
  assign t4a_in.sign_a = t3_out.ksign ^ t3_out.sdx;

  ccint_mul #(.AW(KMW), .BW(W), .TW($bits(t4a_t)), .DIG(DigitWidth)) u_mul_kdx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4s),
    .a_i(t3_out.magk), .b_i(t3_out.magdx), .tag_i(t4a_in),
    .valid_o(v5a), .prod_o(pa), .tag_o(t4a_out)
  );

  ccint_mul #(.AW(KMW), .BW(W), .TW(1), .DIG(DigitWidth)) u_mul_sdy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4s),
    .a_i(KMW'(root)), .b_i(t3_out.magdy), .tag_i(neg_t ^ t3_out.sdy),
    .valid_o(v5b), .prod_o(pb), .tag_o(sgn_b)
  );

  ccint_mul #(.AW(KMW), .BW(W), .TW(1), .DIG(DigitWidth)) u_mul_kdy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4s),
    .a_i(t3_out.magk), .b_i(t3_out.magdy), .tag_i(t3_out.ksign ^ t3_out.sdy),
    .valid_o(v5c), .prod_o(pc), .tag_o(sgn_c)
  );

  ccint_mul #(.AW(KMW), .BW(W), .TW(1), .DIG(DigitWidth)) u_mul_sdx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4s),
    .a_i(KMW'(root)), .b_i(t3_out.magdx), .tag_i(neg_t ^ t3_out.sdx),
    .valid_o(v5d), .prod_o(pd), .tag_o(sgn_d)
  );

  // ---- numerators
  logic [NW-1:0] ta, tb, tc, td;
  logic          v6_q;
  s4_t           s4_q;

  assign ta = t4a_out.sign_a ? -NW'(pa) : NW'(pa);
  assign tb = sgn_b ? -NW'(pb) : NW'(pb);
  assign tc = sgn_c ? -NW'(pc) : NW'(pc);
  assign td = sgn_d ? -NW'(pd) : NW'(pd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.numx  <= ta - tb + NW'(t4a_out.d2);
      s4_q.numy  <= tc + td + NW'(t4a_out.d2);
      s4_q.d2    <= t4a_out.d2;
      s4_q.x0    <= t4a_out.x0;
      s4_q.y0    <= t4a_out.y0;
      s4_q.found <= t4a_out.found;
    end
  end

  // ---- floor division turned into unsigned magnitudes
  logic [DENW-1:0] den_c;
  logic [NW-1:0]   nnx, nny;
  logic            v7_q;
  s5_t             s5_q;

  assign den_c = {s4_q.d2, 1'b0};
  assign nnx   = -s4_q.numx;
  assign nny   = -s4_q.numy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q.negx  <= s4_q.numx[NW-1];
      s5_q.negy  <= s4_q.numy[NW-1];
      s5_q.mx    <= s4_q.numx[NW-1] ? MAGW'(nnx) + MAGW'(den_c) - MAGW'(1)
                                    : MAGW'(s4_q.numx);
      s5_q.my    <= s4_q.numy[NW-1] ? MAGW'(nny) + MAGW'(den_c) - MAGW'(1)
                                    : MAGW'(s4_q.numy);
      s5_q.den   <= den_c;
      s5_q.x0    <= s4_q.x0;
      s5_q.y0    <= s4_q.y0;
      s5_q.found <= s4_q.found;
    end
  end

  logic [MAGW-1:0] den_lim;
  tdx_t            tdx_in, tdx_out;
  tdy_t            tdy_in, tdy_out;
  logic            v8x, v8y;
  logic [QW-1:0]   qx, qy;

  assign den_lim      = MAGW'({s5_q.den, {QW{1'b0}}});
  assign tdx_in.x0    = s5_q.x0;
  assign tdx_in.neg   = s5_q.negx;
  assign tdx_in.ovf   = s5_q.mx >= den_lim;
  assign tdx_in.found = s5_q.found;
  assign tdy_in.y0    = s5_q.y0;
  assign tdy_in.neg   = s5_q.negy;
  assign tdy_in.ovf   = s5_q.my >= den_lim;

  ccint_div #(.DW(DENW), .QW(QW), .TW($bits(tdx_t))) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q),
    .rem_i(s5_q.mx[QW +: DENW]), .bits_i(s5_q.mx[QW-1:0]), .den_i(s5_q.den),
    .tag_i(tdx_in), .valid_o(v8x), .quot_o(qx), .tag_o(tdx_out)
  );

  ccint_div #(.DW(DENW), .QW(QW), .TW($bits(tdy_t))) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q),
    .rem_i(s5_q.my[QW +: DENW]), .bits_i(s5_q.my[QW-1:0]), .den_i(s5_q.den),
    .tag_i(tdy_in), .valid_o(v8y), .quot_o(qy), .tag_o(tdy_out)
  );

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v8x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.found <= tdx_out.found;
      out_q.px    <= tdx_out.found ? place(tdx_out.x0, tdx_out.neg, tdx_out.ovf, qx) : '0;
      out_q.py    <= tdx_out.found ? place(tdy_out.y0, tdy_out.neg, tdy_out.ovf, qy) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // parallel lanes must stay in lockstep
  a_sq_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) v1a == v1b)
    else $error("squaring lanes out of step");
  a_rk_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) v2a == v2b)
    else $error("radius and k lanes out of step");
  a_cross_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v5a == v5b) && (v5a == v5c) && (v5a == v5d))
    else $error("cross product lanes out of step");
  a_div_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) v8x == v8y)
    else $error("divider lanes out of step");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_data_o.found |-> (out_data_o.px == '0) && (out_data_o.py == '0))
    else $error("point not cleared on a miss");

endmodule

`default_nettype wire
